FILE: design/dbd_pkg.sv
// Shared types, constants and register codes of the depth block decompressor.
`default_nettype none

package dbd_pkg;

    localparam int WORD_W     = 32;
    localparam int COLS       = 4;
    localparam int ROWS       = 4;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    localparam logic FMT_Z16   = 1'b0;
    localparam logic FMT_Z24S8 = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_FORMAT = 3'd0,
        REG_ORIGIN_X     = 3'd1,
        REG_ORIGIN_Y     = 3'd2,
        REG_BYTE_SWAP    = 3'd3,
        REG_MULTISAMPLE  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic       depth_format;
        logic [1:0] origin_x;
        logic       origin_y;
        logic       byte_swap;
        logic       multisample;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        depth_format: FMT_Z16,
        origin_x:     2'd2,
        origin_y:     1'b0,
        byte_swap:    1'b0,
        multisample:  1'b0
    };

endpackage

`default_nettype wire

FILE: design/depth_block_decompressor.sv
// Top level of the depth block decompressor: block register, row sequencer, result register.
//
// Usage: one compressed 128-bit depth block enters on the input channel
// (in_valid/in_ready) as in_word0..in_word3 in one transaction. The block
// leaves on the output channel (out_valid/out_ready) as four transactions,
// rows 0 to 3 in order, each carrying row_index, four 32-bit words and
// last_row, which is set on row 3.
// The block is held in an input register; whenever the result register is
// free, the row logic turns the current row into words that load it. Row 0
// is presented once the block has passed the input register and then the
// result register, and rows follow one per cycle while the receiver takes
// them. A new block is taken in the same cycle as the last row of the
// previous one loads the result register; the single result port sets the block rate.
// If the receiver stalls, the result register holds its row and the row
// sequencer waits; in_ready drops once a block is waiting.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
// always taken and must only be made while no block is in flight.
// Reset empties both registers and restores the default configuration.
`default_nettype none

module depth_block_decompressor
    import dbd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [WORD_W-1:0]     in_word0,
    input  wire logic [WORD_W-1:0]     in_word1,
    input  wire logic [WORD_W-1:0]     in_word2,
    input  wire logic [WORD_W-1:0]     in_word3,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [ROW_W-1:0]           row_index,
    output logic [WORD_W-1:0]          out_word0,
    output logic [WORD_W-1:0]          out_word1,
    output logic [WORD_W-1:0]          out_word2,
    output logic [WORD_W-1:0]          out_word3,
    output logic                       last_row
);

    cfg_t cfg;

    logic                        blk_valid_reg;
    logic                        blk_valid_next;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            row_next;
    logic [COLS-1:0][WORD_W-1:0] blk_word_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ROW_W-1:0]            out_row_reg;
    logic [COLS-1:0][WORD_W-1:0] out_word_reg;
    logic [COLS-1:0][WORD_W-1:0] row_word;
    logic                        in_take;
    logic                        out_free;
    logic                        step;

    dbd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbd_row_calc u_row_calc (
        .blk_word (blk_word_reg),
        .row      (row_reg),
        .cfg      (cfg),
        .row_word (row_word)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign step     = blk_valid_reg && out_free;
    assign in_ready = !blk_valid_reg || (step && (row_reg == LAST_ROW));
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            row_next = row_reg + ROW_W'(1);
            if (row_reg == LAST_ROW)
            begin
                blk_valid_next = 1'b0;
            end
        end
        if (in_take)
        begin
            blk_valid_next = 1'b1;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            blk_word_reg <= {in_word3, in_word2, in_word1, in_word0};
        end
        if (step)
        begin
            out_row_reg  <= row_reg;
            out_word_reg <= row_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = out_row_reg;
    assign out_word0 = out_word_reg[0];
    assign out_word1 = out_word_reg[1];
    assign out_word2 = out_word_reg[2];
    assign out_word3 = out_word_reg[3];
    assign last_row  = (out_row_reg == LAST_ROW);

`ifndef ASSERT_OFF
    a_idle_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !blk_valid_reg |-> (row_reg == '0))
        else $error("row counter is not at row 0 while no block is held");

    a_step_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && (out_row_reg == $past(row_reg))))
        else $error("row step did not load the result register");

    a_take_starts_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (blk_valid_reg && (row_reg == '0)))
        else $error("taken block did not start at row 0");

    a_take_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && blk_valid_reg) |-> (step && (row_reg == LAST_ROW)))
        else $error("block taken before the held block finished");
`endif

endmodule

`default_nettype wire

FILE: design/dbd_cfg_regs.sv
// Configuration register file written through the configuration channel.
`default_nettype none

module dbd_cfg_regs
    import dbd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEPTH_FORMAT: cfg_next.depth_format = cfg_data[0];
                REG_ORIGIN_X:     cfg_next.origin_x     = cfg_data[1:0];
                REG_ORIGIN_Y:     cfg_next.origin_y     = cfg_data[0];
                REG_BYTE_SWAP:    cfg_next.byte_swap    = cfg_data[0];
                REG_MULTISAMPLE:  cfg_next.multisample  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dbd_row_calc.sv
// Combinational evaluation of one tile row from a held compressed block.
`default_nettype none

module dbd_row_calc
    import dbd_pkg::*;
(
    input  wire logic [COLS-1:0][WORD_W-1:0] blk_word,
    input  wire logic [ROW_W-1:0]            row,
    input  wire cfg_t                        cfg,
    output logic [COLS-1:0][WORD_W-1:0]      row_word
);

    // Samples that carry no delta code in the current layout.
    function automatic logic is_empty(logic fmt, logic o3, logic ms,
                                      logic [2:0] x, logic [1:0] y);
        logic [2:0] a;
        logic [2:0] b;
        logic       e;
        a = o3 ? 3'd3 : 3'd2;
        b = ms ? 3'd3 : 3'd2;
        if (fmt == FMT_Z16)
        begin
            e = ((y == 2'd0) && ((x == a) || (x == a + 3'd2))) ||
                ((y == 2'd2) && (x == a));
        end
        else
        begin
            e = ((x == 3'd1) && ((y == 2'd1) || (y == 2'd2))) ||
                ((y == 2'd1) && (x == b));
        end
        return e;
    endfunction

    // Bit position of a sample's delta code in the squeezed stream.
    function automatic logic [6:0] code_pos(logic fmt, logic o3, logic ms,
                                            logic [2:0] x, logic [1:0] y);
        logic [2:0] a;
        logic [2:0] b;
        logic [4:0] skip;
        logic [4:0] n;
        logic [6:0] p;
        a = o3 ? 3'd3 : 3'd2;
        b = ms ? 3'd3 : 3'd2;
        if (fmt == FMT_Z16)
        begin
            case (y)
                2'd0:    skip = 5'(x > a) + 5'(x > (a + 3'd2));
                2'd1:    skip = 5'd2;
                2'd2:    skip = 5'd2 + 5'(x > a);
                default: skip = 5'd3;
            endcase
            n = {y, x} - skip;
            p = 7'd40 + 7'(n) * 7'd3;
        end
        else
        begin
            case (y)
                2'd0:    skip = 5'd0;
                2'd1:    skip = 5'(x > 3'd1) + 5'(x > b);
                2'd2:    skip = 5'd2 + 5'(x > 3'd1);
                default: skip = 5'd3;
            endcase
            n = 5'({y, x[1:0]}) - skip;
            p = 7'd62 + 7'(n) * 7'd5;
        end
        return p;
    endfunction

    logic               fmt;
    logic               short_blk;
    logic [63:0]        w0;
    logic [63:0]        w1;
    logic [127:0]       stream;
    logic [31:0]        base;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         stencil;

    assign fmt       = cfg.depth_format;
    assign w0        = {blk_word[1], blk_word[0]};
    assign short_blk = w0[63];
    assign w1        = short_blk ? 64'd0 : {blk_word[3], blk_word[2]};
    assign stream    = {1'b0, w1, w0[62:0]};
    assign stencil   = w0[7:0];

    always_comb
    begin
        if (fmt == FMT_Z16)
        begin
            base = {16'd0, w0[15:0]};
            dx   = {{4{w0[27]}}, w0[27:16]};
            dy   = {{4{w0[39]}}, w0[39:28]};
        end
        else
        begin
            base = {8'd0, w0[31:8]};
            dx   = {w0[46], w0[46:32]};
            dy   = {w0[61], w0[61:47]};
        end
    end

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        logic [1:0][15:0] half;
        logic [31:0]      full;

        for (genvar h = 0; h < 2; h++)
        begin : g_smp
            logic [2:0]         x;
            logic signed [5:0]  ox;
            logic signed [5:0]  oy;
            logic signed [5:0]  fa;
            logic signed [5:0]  fb;
            logic signed [21:0] pa;
            logic signed [21:0] pb;
            logic [31:0]        k;
            logic [31:0]        acc;
            logic [31:0]        dz;
            logic [6:0]         pos;
            logic [127:0]       raw;
            logic [31:0]        d;
            logic [31:0]        sum;
            logic [15:0]        s16;
            logic [31:0]        v32;

            always_comb
            begin
                if (h == 0)
                begin
                    x = (fmt == FMT_Z16) ? 3'(2 * c) : 3'(c);
                end
                else
                begin
                    x = 3'(2 * c + 1);
                end
                ox = 6'({3'b000, x}) - 6'({4'b0000, cfg.origin_x});
                oy = 6'({4'b0000, row}) - 6'({5'b00000, cfg.origin_y});
                fa = ((fmt == FMT_Z16) && cfg.multisample) ? (ox <<< 1) : ox;
                fb = cfg.multisample ? ((oy <<< 1) - 6'({5'b00000, ox[0]})) : oy;
                pa = dx * fa;
                pb = dy * fb;

                if (fmt == FMT_Z16)
                begin
                    if (cfg.multisample)
                    begin
                        k = (row != '0) ? 32'd2 : 32'd3;
                    end
                    else
                    begin
                        k = 32'd1;
                    end
                end
                else
                begin
                    k = cfg.multisample ? 32'd1 : 32'd0;
                end

                acc = {{10{pa[21]}}, pa} + {{10{pb[21]}}, pb} + k;

                if (fmt == FMT_Z16)
                begin
                    dz = cfg.multisample ? (acc >> 2) : (acc >> 1);
                end
                else
                begin
                    dz = cfg.multisample ? (acc >> 1) : acc;
                end

                pos = code_pos(fmt, cfg.origin_x == 2'd3, cfg.multisample, x, row);
                raw = stream >> pos;
                if (is_empty(fmt, cfg.origin_x == 2'd3, cfg.multisample, x, row))
                begin
                    d = 32'd0;
                end
                else if (fmt == FMT_Z16)
                begin
                    d = {{29{raw[2]}}, raw[2:0]};
                end
                else
                begin
                    d = {{27{raw[4]}}, raw[4:0]};
                end

                sum = base + dz + d;
                s16 = sum[15:0];
                v32 = {sum[23:0], stencil};
            end

            if (h == 0)
            begin : g_full
                always_comb
                begin
                    full = cfg.byte_swap ? {v32[7:0], v32[15:8], v32[23:16], v32[31:24]}
                                         : v32;
                end
            end

            assign half[h] = cfg.byte_swap ? {s16[7:0], s16[15:8]} : s16;
        end

        assign row_word[c] = (fmt == FMT_Z24S8) ? full : {half[1], half[0]};
    end

endmodule

`default_nettype wire
